>>> hw/rtl/slbs_pkg.sv
// ----------------------------------------------------------------------------
// slbs_pkg - status LED blink sequencer shared definitions
// Codes, state record and the status pattern table.
// ----------------------------------------------------------------------------
package slbs_pkg;

    localparam int BLIP_FLASHES_DEF = 2;

    localparam int MS_W  = 14;
    localparam int COL_W = 24;

    // func codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_STATUS = 2'd1;
    localparam logic [1:0] FUNC_BLIP   = 2'd2;

    // led_kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PLAIN = 2'd1;
    localparam logic [1:0] KIND_RGB   = 2'd2;

    // pulse phase codes
    localparam logic [1:0] PH_BOUNDARY = 2'd0;
    localparam logic [1:0] PH_LIT      = 2'd1;
    localparam logic [1:0] PH_DARK     = 2'd2;

    // pending blip codes
    localparam logic [1:0] BLIP_NONE = 2'd0;
    localparam logic [1:0] BLIP_OK   = 2'd1;
    localparam logic [1:0] BLIP_FAIL = 2'd2;

    // status codes
    localparam logic [2:0] ST_OFF       = 3'd0;
    localparam logic [2:0] ST_WATCHING  = 3'd1;
    localparam logic [2:0] ST_MISSING   = 3'd2;
    localparam logic [2:0] ST_WAKING    = 3'd3;
    localparam logic [2:0] ST_NO_NET    = 3'd4;
    localparam logic [2:0] ST_NOT_CONF  = 3'd5;

    localparam logic [MS_W-1:0]  BLIP_ON_MS  = 14'd60;
    localparam logic [MS_W-1:0]  BLIP_OFF_MS = 14'd60;
    localparam logic [COL_W-1:0] COL_WHITE   = 24'h282828;
    localparam logic [COL_W-1:0] COL_RED     = 24'h3C0000;

    typedef struct packed {
        logic [COL_W-1:0] colour;
        logic [MS_W-1:0]  on_ms;
        logic [MS_W-1:0]  off_ms;
    } t_pattern;

    typedef struct packed {
        logic [2:0]       shown_status;
        logic [1:0]       blip_pending;
        logic             blip_success;
        logic [1:0]       flashes_left;
        logic [1:0]       phase;
        logic [MS_W-1:0]  ms_left;
        logic [COL_W-1:0] colour;
        logic [MS_W-1:0]  dark_len;
    } t_state;

    function automatic t_pattern status_pattern(input logic [2:0] status);
        t_pattern p;
        case (status)
            ST_WATCHING: p = '{24'h000C00, 14'd40,  14'd4960};
            ST_MISSING:  p = '{24'h140C00, 14'd120, 14'd880};
            ST_WAKING:   p = '{24'h280000, 14'd120, 14'd200};
            ST_NO_NET:   p = '{24'h1E0800, 14'd300, 14'd300};
            ST_NOT_CONF: p = '{24'h00001E, 14'd500, 14'd500};
            default:     p = '{24'h06000C, 14'd30,  14'd9970}; // off and unknown
        endcase
        return p;
    endfunction

endpackage

>>> hw/rtl/slbs_in_if.sv
// ----------------------------------------------------------------------------
// slbs_in_if - command channel
// One beat is a tick, a status change or a blip request.
// ----------------------------------------------------------------------------
interface slbs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [2:0] status;
    logic       success;

    modport source (output valid, output func, output status, output success, input ready);
    modport sink   (input valid, input func, input status, input success, output ready);
endinterface

>>> hw/rtl/slbs_out_if.sv
// ----------------------------------------------------------------------------
// slbs_out_if - LED level channel
// One beat carries the RGB drive and the plain lamp level.
// ----------------------------------------------------------------------------
interface slbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       lamp_on;

    modport source (output valid, output red, output green, output blue, output lamp_on,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input lamp_on,
                    output ready);
endinterface

>>> hw/rtl/slbs_cfg_if.sv
// ----------------------------------------------------------------------------
// slbs_cfg_if - configuration write channel
// One beat writes the LED kind register.
// ----------------------------------------------------------------------------
interface slbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] led_kind;

    modport source (output valid, output led_kind, input ready);
    modport sink   (input valid, input led_kind, output ready);
endinterface

>>> hw/rtl/slbs_step.sv
// ----------------------------------------------------------------------------
// slbs_step - next-state logic of the sequencer
// Tick countdown, phase changes, blip arbitration and status lookup.
// ----------------------------------------------------------------------------
module slbs_step #(
    parameter int BLIP_FLASHES = slbs_pkg::BLIP_FLASHES_DEF
) (
    input  slbs_pkg::t_state i_state,
    input  logic [1:0]       i_func,
    input  logic [2:0]       i_status,
    input  logic             i_success,
    output slbs_pkg::t_state o_next
);

    always_comb begin
        slbs_pkg::t_state s;
        slbs_pkg::t_pattern p;
        s = i_state;
        p = slbs_pkg::status_pattern(i_state.shown_status);
        case (i_func)
            slbs_pkg::FUNC_TICK: begin
                if (s.phase != slbs_pkg::PH_BOUNDARY) begin
                    if (s.ms_left != '0) begin
                        s.ms_left = s.ms_left - 1'b1;
                    end
                    if (s.ms_left == '0) begin
                        if (s.phase == slbs_pkg::PH_LIT) begin
                            s.colour  = '0;
                            s.ms_left = s.dark_len;
                            s.phase   = (s.dark_len == '0) ? slbs_pkg::PH_BOUNDARY
                                                           : slbs_pkg::PH_DARK;
                        end else begin
                            s.phase = slbs_pkg::PH_BOUNDARY;
                        end
                    end
                end
                // new pulse starts on the same tick as the boundary
                if (s.phase == slbs_pkg::PH_BOUNDARY) begin
                    s.phase = slbs_pkg::PH_LIT;
                    if (s.flashes_left != '0 || s.blip_pending != slbs_pkg::BLIP_NONE) begin
                        if (s.flashes_left != '0) begin
                            s.flashes_left = s.flashes_left - 1'b1;
                        end else begin
                            s.blip_success = (s.blip_pending == slbs_pkg::BLIP_OK);
                            s.blip_pending = slbs_pkg::BLIP_NONE;
                            s.flashes_left = 2'(BLIP_FLASHES - 1);
                        end
                        s.colour   = s.blip_success ? slbs_pkg::COL_WHITE : slbs_pkg::COL_RED;
                        s.ms_left  = slbs_pkg::BLIP_ON_MS;
                        s.dark_len = slbs_pkg::BLIP_OFF_MS;
                    end else begin
                        s.colour   = p.colour;
                        s.ms_left  = p.on_ms;
                        s.dark_len = p.off_ms;
                    end
                end
            end
            slbs_pkg::FUNC_STATUS: s.shown_status = i_status;
            slbs_pkg::FUNC_BLIP:   s.blip_pending = i_success ? slbs_pkg::BLIP_OK
                                                              : slbs_pkg::BLIP_FAIL;
            default: ;             // unused code, no change
        endcase
        o_next = s;
    end

endmodule

>>> hw/rtl/status_led_blink_sequencer.sv
// ----------------------------------------------------------------------------
// status_led_blink_sequencer - status LED pulse and blip sequencer
// Drives an RGB or plain status LED from millisecond ticks and events.
// ----------------------------------------------------------------------------
// Every command beat (tick, status change, blip request) yields exactly one
// LED level beat, showing the colour after that command has been applied.
// One beat is taken per clock while the output is not stalled: the
// sequencer state and the output register both update at the accepting
// edge, and the result is presented from the next cycle.
// A new command is taken while a finished result is being drained; the only
// thing that holds input off is a full output register with o_out.ready low.
// A pulse is lit for the status on-time and dark for its off-time, counted
// in tick beats; a pending blip is only looked at on a pulse boundary, then
// plays BLIP_FLASHES flashes of 60 ms lit / 60 ms dark (white on success,
// red on failure). led_kind selects RGB output, a plain lamp level, or
// nothing. Write led_kind only while idle. No clearing pass after reset.
// ----------------------------------------------------------------------------
module status_led_blink_sequencer #(
    parameter int BLIP_FLASHES = slbs_pkg::BLIP_FLASHES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slbs_in_if.sink     i_in,
    slbs_cfg_if.sink    i_cfg,
    slbs_out_if.source  o_out
);

    slbs_pkg::t_state r_state;
    slbs_pkg::t_state n_state;
    logic [1:0]       r_kind;
    logic             r_out_valid;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic             r_lamp;
    logic             in_fire;

    // take a beat whenever the result register is free or drains this cycle
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    slbs_step #(
        .BLIP_FLASHES (BLIP_FLASHES)
    ) u_step (
        .i_state   (r_state),
        .i_func    (i_in.func),
        .i_status  (i_in.status),
        .i_success (i_in.success),
        .o_next    (n_state)
    );

    // sequencer state; idle at a boundary showing the not-configured status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{slbs_pkg::ST_NOT_CONF, slbs_pkg::BLIP_NONE, 1'b0, 2'd0,
                         slbs_pkg::PH_BOUNDARY, '0, '0, '0};
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // led_kind register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= slbs_pkg::KIND_NONE;
        end else if (i_cfg.valid) begin
            r_kind <= i_cfg.led_kind;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (r_kind == slbs_pkg::KIND_RGB) begin
                r_red   <= n_state.colour[23:16];
                r_green <= n_state.colour[15:8];
                r_blue  <= n_state.colour[7:0];
            end else begin
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end
            r_lamp <= (r_kind == slbs_pkg::KIND_PLAIN) && (n_state.colour != '0);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.red     = r_red;
    assign o_out.green   = r_green;
    assign o_out.blue    = r_blue;
    assign o_out.lamp_on = r_lamp;

    // a tick always leaves a pulse running
    a_tick_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.func == slbs_pkg::FUNC_TICK |=> r_state.phase != slbs_pkg::PH_BOUNDARY)
        else $error("pulse not started on tick");

    // dark phase shows black
    a_dark_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == slbs_pkg::PH_DARK |-> r_state.colour == '0)
        else $error("colour lit during dark phase");

    // owed flashes only exist inside a running pulse
    a_flash_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.flashes_left != '0 |-> r_state.phase != slbs_pkg::PH_BOUNDARY)
        else $error("blip flash owed at idle boundary");

endmodule
